// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(lbl, ck, rstn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (cond)) \
		else $error("invariant violated");

// Check that a consequent holds whenever an antecedent holds.
`define SPQ_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

// File: hw/rtl/spq_pkg.sv
package spq_pkg;

	localparam int CAPACITY    = 16;
	localparam int ID_BITS     = 16;
	localparam int TYPE_BITS   = 16;
	localparam int PRIO_BITS   = 16;
	localparam int STATUS_BITS = 3;
	localparam int IDX_BITS    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_BITS    = $clog2(CAPACITY + 1);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_OK    = 3'd0,
		ST_NULL  = 3'd1,
		ST_DUP   = 3'd2,
		ST_FULL  = 3'd3,
		ST_EMPTY = 3'd4
	} spq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DUP_RD,
		S_DUP_CHK,
		S_SHF_RD,
		S_SHF_CHK,
		S_POP_RD,
		S_POP_DATA,
		S_FIN
	} spq_state_t;

	typedef struct packed {
		logic [ID_BITS-1:0]          id;
		logic [TYPE_BITS-1:0]        item_type;
		logic signed [PRIO_BITS-1:0] prio;
	} spq_entry_t;

	typedef struct packed {
		logic                we;
		logic [IDX_BITS-1:0] waddr;
		spq_entry_t          wdata;
		logic [IDX_BITS-1:0] raddr;
	} spq_mem_req_t;

	typedef struct packed {
		spq_status_t                 status;
		logic [ID_BITS-1:0]          out_item_id;
		logic [TYPE_BITS-1:0]        out_item_type;
		logic signed [PRIO_BITS-1:0] out_priority;
		logic [CNT_BITS-1:0]         count_before;
		logic [CNT_BITS-1:0]         count_after;
	} spq_rsp_t;

endpackage

// File: hw/rtl/spq_if.sv
interface spq_req_if;
	import spq_pkg::*;

	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [ID_BITS-1:0]          item_id;
	logic [TYPE_BITS-1:0]        item_type;
	logic signed [PRIO_BITS-1:0] priority_req;

	modport source (output valid, kind, item_id, item_type, priority_req, input ready);
	modport sink (input valid, kind, item_id, item_type, priority_req, output ready);
endinterface

interface spq_rsp_if;
	import spq_pkg::*;

	logic                        valid;
	logic                        ready;
	logic [STATUS_BITS-1:0]      status;
	logic [ID_BITS-1:0]          out_item_id;
	logic [TYPE_BITS-1:0]        out_item_type;
	logic signed [PRIO_BITS-1:0] out_priority;
	logic [CNT_BITS-1:0]         count_before;
	logic [CNT_BITS-1:0]         count_after;

	modport source (output valid, status, out_item_id, out_item_type, out_priority,
		count_before, count_after, input ready);
	modport sink (input valid, status, out_item_id, out_item_type, out_priority,
		count_before, count_after, output ready);
endinterface

// File: hw/rtl/spq_ram.sv
module spq_ram (
	input  logic                  clk,
	input  spq_pkg::spq_mem_req_t mem_req,
	output spq_pkg::spq_entry_t   rdata
);
	import spq_pkg::*;

	spq_entry_t mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (mem_req.we) begin
			mem[mem_req.waddr] <= mem_req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[mem_req.raddr];
	end

endmodule

// File: hw/rtl/spq_ctrl.sv
`include "assert_macros.svh"

module spq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	spq_req_if.sink               req,
	output spq_pkg::spq_rsp_t     res,
	output logic                  res_valid,
	input  logic                  res_ready,
	output spq_pkg::spq_mem_req_t mem_req,
	input  spq_pkg::spq_entry_t   mem_rdata
);
	import spq_pkg::*;

	localparam int SUM_BITS = IDX_BITS + 1;

	spq_state_t          state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic [IDX_BITS-1:0] head_q, head_d;
	logic [CNT_BITS-1:0] lidx_q, lidx_d;
	spq_entry_t          op_q;
	spq_rsp_t            res_q, res_d;
	logic [CNT_BITS-1:0] lidx_m1;

	function automatic logic [IDX_BITS-1:0] phys(input logic [IDX_BITS-1:0] h,
		input logic [CNT_BITS-1:0] l);
		logic [SUM_BITS-1:0] s;
		s = SUM_BITS'(h) + SUM_BITS'(l);
		if (s >= SUM_BITS'(CAPACITY)) begin
			s = s - SUM_BITS'(CAPACITY);
		end
		return s[IDX_BITS-1:0];
	endfunction

	assign lidx_m1   = lidx_q - CNT_BITS'(1);
	assign req.ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_FIN);
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		head_d  = head_q;
		lidx_d  = lidx_q;
		res_d   = res_q;

		mem_req.we    = 1'b0;
		mem_req.waddr = phys(head_q, lidx_q);
		mem_req.wdata = op_q;
		mem_req.raddr = phys(head_q, lidx_q);

		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					res_d.status        = ST_OK;
					res_d.out_item_id   = '0;
					res_d.out_item_type = '0;
					res_d.out_priority  = '0;
					res_d.count_before  = cnt_q;
					res_d.count_after   = cnt_q;
					lidx_d              = '0;
					if (req.kind == KIND_REMOVE) begin
						if (cnt_q == '0) begin
							res_d.status = ST_EMPTY;
							state_d      = S_FIN;
						end else begin
							state_d = S_POP_RD;
						end
					end else if (req.item_id == '0) begin
						res_d.status = ST_NULL;
						state_d      = S_FIN;
					end else if (cnt_q == '0) begin
						state_d = S_SHF_RD;
					end else begin
						state_d = S_DUP_RD;
					end
				end
			end
			S_DUP_RD: begin
				state_d = S_DUP_CHK;
			end
			S_DUP_CHK: begin
				if (mem_rdata.id == op_q.id) begin
					res_d.status = ST_DUP;
					state_d      = S_FIN;
				end else if (lidx_q + CNT_BITS'(1) == cnt_q) begin
					if (cnt_q == CNT_BITS'(CAPACITY)) begin
						res_d.status = ST_FULL;
						state_d      = S_FIN;
					end else begin
						lidx_d  = cnt_q;
						state_d = S_SHF_RD;
					end
				end else begin
					lidx_d  = lidx_q + CNT_BITS'(1);
					state_d = S_DUP_RD;
				end
			end
			S_SHF_RD: begin
				if (lidx_q == '0) begin
					mem_req.we        = 1'b1;
					cnt_d             = cnt_q + CNT_BITS'(1);
					res_d.count_after = cnt_q + CNT_BITS'(1);
					state_d           = S_FIN;
				end else begin
					mem_req.raddr = phys(head_q, lidx_m1);
					state_d       = S_SHF_CHK;
				end
			end
			S_SHF_CHK: begin
				mem_req.we = 1'b1;
				if ($signed(op_q.prio) < $signed(mem_rdata.prio)) begin
					mem_req.wdata = mem_rdata;
					lidx_d        = lidx_m1;
					state_d       = S_SHF_RD;
				end else begin
					cnt_d             = cnt_q + CNT_BITS'(1);
					res_d.count_after = cnt_q + CNT_BITS'(1);
					state_d           = S_FIN;
				end
			end
			S_POP_RD: begin
				state_d = S_POP_DATA;
			end
			S_POP_DATA: begin
				res_d.out_item_id   = mem_rdata.id;
				res_d.out_item_type = mem_rdata.item_type;
				res_d.out_priority  = mem_rdata.prio;
				res_d.count_after   = cnt_q - CNT_BITS'(1);
				cnt_d               = cnt_q - CNT_BITS'(1);
				if (head_q == IDX_BITS'(CAPACITY - 1)) begin
					head_d = '0;
				end else begin
					head_d = head_q + IDX_BITS'(1);
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			head_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			head_q  <= head_d;
		end
	end

	always_ff @(posedge clk) begin
		lidx_q <= lidx_d;
		res_q  <= res_d;
		if (req.valid && req.ready) begin
			op_q.id        <= req.item_id;
			op_q.item_type <= req.item_type;
			op_q.prio      <= req.priority_req;
		end
	end

	`SPQ_ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_BITS'(CAPACITY))
	`SPQ_ASSERT_IMP(a_write_in_shift, clk, arst_n, mem_req.we,
		state_q == S_SHF_RD || state_q == S_SHF_CHK)

endmodule

// File: hw/rtl/stable_priority_queue.sv
// Stable priority queue of up to CAPACITY tagged entries.
// Channel req takes one operation per transfer: kind 0 inserts item_id with
// item_type and priority_req, kind 1 removes the head entry. Channel rsp
// gives exactly one result per operation, in order, with a status, the
// removed entry (zeros otherwise) and the entry count before and after.
// Entries sit in one single-port-write, registered-read RAM arranged as a
// ring; removal advances the head pointer, insertion scans for a duplicate
// id and then moves larger-priority entries up one slot toward the tail.
// A remove reads the head entry; an empty remove and a null insert go
// straight to the result. An insert scans the stored ids in turn for a
// duplicate (none when empty), rejects a full queue once the scan ends, then
// moves entries up from the tail until the new entry finds its slot.
// Each RAM step is a read state followed by a compare state. One operation
// is in work at a time; the next req transfer can come in the same cycle
// that rsp valid rises. req accepts the next one while a finished result
// still waits in the rsp output register.
// When rsp stalls, the result holds and the next operation stalls at its end.
// Reset empties the queue at once; no clearing pass is needed.
`include "assert_macros.svh"

module stable_priority_queue (
	input  logic     clk,
	input  logic     arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	spq_mem_req_t mem_req;
	spq_entry_t   mem_rdata;
	spq_rsp_t     res;
	logic         res_valid;
	logic         res_ready;
	spq_rsp_t     out_q;
	logic         ovalid_q;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	spq_ram u_ram (
		.clk     (clk),
		.mem_req (mem_req),
		.rdata   (mem_rdata)
	);

	assign res_ready = !ovalid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = ovalid_q;
	assign rsp.status        = STATUS_BITS'(out_q.status);
	assign rsp.out_item_id   = out_q.out_item_id;
	assign rsp.out_item_type = out_q.out_item_type;
	assign rsp.out_priority  = out_q.out_priority;
	assign rsp.count_before  = out_q.count_before;
	assign rsp.count_after   = out_q.count_after;

	`SPQ_ASSERT_IMP(a_insert_grows, clk, arst_n,
		ovalid_q && out_q.status == ST_OK && out_q.out_item_id == '0,
		out_q.count_after == out_q.count_before + CNT_BITS'(1))
	`SPQ_ASSERT_IMP(a_reject_keeps, clk, arst_n,
		ovalid_q && out_q.status != ST_OK,
		out_q.count_after == out_q.count_before)

endmodule

// File: sim/spq_checker.sv
`timescale 1ns / 100ps

module spq_checker (
	input  logic clk,
	input  logic arst_n,
	spq_req_if   req,
	spq_rsp_if   rsp,
	output int   fail_count,
	output int   pending,
	output int   checked,
	output int   peak_fill
);
	import spq_pkg::*;

	logic [ID_BITS-1:0]          slot_id   [CAPACITY];
	logic [TYPE_BITS-1:0]        slot_type [CAPACITY];
	logic signed [PRIO_BITS-1:0] slot_prio [CAPACITY];
	logic [CNT_BITS-1:0]         fill;

	spq_rsp_t due_results[$];

	task automatic apply_queue_op(
		input  logic                        op_kind,
		input  logic [ID_BITS-1:0]          op_id,
		input  logic [TYPE_BITS-1:0]        op_type,
		input  logic signed [PRIO_BITS-1:0] op_prio,
		output spq_rsp_t                    res
	);
		int   pos;
		logic dup;
		res = '0;
		res.status = ST_OK;
		res.count_before = fill;
		if (op_kind == KIND_INSERT) begin
			dup = 1'b0;
			for (int i = 0; i < int'(fill); i++)
				if (slot_id[i] == op_id)
					dup = 1'b1;
			if (op_id == '0) begin
				res.status = ST_NULL;
			end else if (dup) begin
				res.status = ST_DUP;
			end else if (int'(fill) >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < int'(fill) && op_prio >= slot_prio[pos])
					pos++;
				for (int i = int'(fill); i > pos; i--) begin
					slot_id[i]   = slot_id[i-1];
					slot_type[i] = slot_type[i-1];
					slot_prio[i] = slot_prio[i-1];
				end
				slot_id[pos]   = op_id;
				slot_type[pos] = op_type;
				slot_prio[pos] = op_prio;
				fill = fill + CNT_BITS'(1);
			end
		end else begin
			if (fill == '0) begin
				res.status = ST_EMPTY;
			end else begin
				res.out_item_id   = slot_id[0];
				res.out_item_type = slot_type[0];
				res.out_priority  = slot_prio[0];
				for (int i = 1; i < int'(fill); i++) begin
					slot_id[i-1]   = slot_id[i];
					slot_type[i-1] = slot_type[i];
					slot_prio[i-1] = slot_prio[i];
				end
				fill = fill - CNT_BITS'(1);
			end
		end
		res.count_after = fill;
	endtask

	task automatic compare_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		spq_rsp_t res;
		spq_rsp_t want;
		if (!arst_n) begin
			fill = '0;
			due_results.delete();
			pending <= 0;
			fail_count = 0;
			checked <= 0;
			peak_fill <= 0;
		end else begin
			if (req.valid && req.ready) begin
				apply_queue_op(req.kind, req.item_id, req.item_type, req.priority_req, res);
				due_results.push_back(res);
				if (int'(fill) > peak_fill)
					peak_fill <= int'(fill);
			end
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result transfer with none expected, actual status %0h id %0h",
						$time, rsp.status, rsp.out_item_id);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					compare_field("status", 32'(want.status), 32'(rsp.status));
					compare_field("out_item_id", 32'(want.out_item_id), 32'(rsp.out_item_id));
					compare_field("out_item_type", 32'(want.out_item_type),
						32'(rsp.out_item_type));
					compare_field("out_priority", {16'b0, want.out_priority},
						{16'b0, rsp.out_priority});
					compare_field("count_before", 32'(want.count_before),
						32'(rsp.count_before));
					compare_field("count_after", 32'(want.count_after), 32'(rsp.count_after));
					checked <= checked + 1;
				end
			end
			pending <= due_results.size();
		end
	end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import spq_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 450;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AT      = 150;
	localparam int PAUSE_AT     = 350;

	logic clk = 1'b0;
	logic arst_n;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	int fail_count;
	int pending;
	int checked;
	int peak_fill;

	int  cycle_count = 0;
	int  sent_count = 0;
	int  n_insert = 0;
	int  n_remove = 0;
	bit  quiet = 1'b0;
	bit  hold_done = 1'b0;

	stable_priority_queue DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	spq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.peak_fill  (peak_fill)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
			$display("** stable_priority_queue: FAILED **");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65)
			return 0;
		else if (r < 95)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic send_op(
		input logic                        op_kind,
		input logic [ID_BITS-1:0]          op_id,
		input logic [TYPE_BITS-1:0]        op_type,
		input logic signed [PRIO_BITS-1:0] op_prio
	);
		int gap;
		req_ch.valid        <= 1'b1;
		req_ch.kind         <= op_kind;
		req_ch.item_id      <= op_id;
		req_ch.item_type    <= op_type;
		req_ch.priority_req <= op_prio;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent_count++;
		if (op_kind == KIND_INSERT)
			n_insert++;
		else
			n_remove++;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin : result_sink
		int stall;
		stall = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && sent_count >= HOLD_AT) begin
				hold_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				stall--;
			end else begin
				rsp_ch.ready <= 1'b1;
				if (!quiet && $urandom_range(99) < 20)
					stall = pick_gap();
			end
		end
	end

	initial begin : op_source
		logic                        kind_r;
		logic [ID_BITS-1:0]          id_r;
		logic signed [PRIO_BITS-1:0] prio_r;
		int                          r;
		bit                          filling;

		arst_n = 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.kind         <= KIND_INSERT;
		req_ch.item_id      <= '0;
		req_ch.item_type    <= '0;
		req_ch.priority_req <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(KIND_REMOVE, ID_BITS'($urandom), TYPE_BITS'($urandom), PRIO_BITS'($urandom));
		send_op(KIND_INSERT, 16'h0000, 16'hffff, 16'sh7fff);
		send_op(KIND_INSERT, 16'hffff, 16'hffff, 16'sh7fff);
		send_op(KIND_INSERT, 16'h0001, 16'h0000, -16'sh8000);
		send_op(KIND_INSERT, 16'hffff, 16'h1234, 16'sh0000);
		send_op(KIND_INSERT, 16'h0010, 16'haaaa, 16'sh0005);
		send_op(KIND_INSERT, 16'h0011, 16'h5555, 16'sh0005);
		send_op(KIND_INSERT, 16'h0012, 16'h00ff, 16'sh0005);
		send_op(KIND_INSERT, 16'h0013, 16'hff00, 16'sh7fff);
		send_op(KIND_INSERT, 16'h0014, 16'h8001, -16'sh8000);
		for (int k = 0; k < 9; k++)
			send_op(KIND_INSERT, 16'(32 + k), TYPE_BITS'($urandom), 16'(k * 1000 - 4000));
		send_op(KIND_INSERT, 16'h0001, 16'h7777, 16'sh0001);
		send_op(KIND_INSERT, 16'h0000, 16'h7777, 16'sh0001);
		send_op(KIND_INSERT, 16'h0099, 16'h7777, 16'sh0001);
		repeat (3)
			send_op(KIND_REMOVE, ID_BITS'($urandom), TYPE_BITS'($urandom),
				PRIO_BITS'($urandom));

		filling = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				filling = !filling;
			quiet = (i >= 250 && i < 320);
			if (i == PAUSE_AT) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			kind_r = ($urandom_range(99) < (filling ? 75 : 25)) ? KIND_INSERT : KIND_REMOVE;
			r = $urandom_range(99);
			if (r < 4)
				id_r = '0;
			else if (r < 60)
				id_r = ID_BITS'($urandom_range(1, 24));
			else
				id_r = ID_BITS'($urandom);
			r = $urandom_range(99);
			if (r < 50)
				prio_r = PRIO_BITS'($urandom_range(0, 4)) - 16'sd2;
			else if (r < 60)
				prio_r = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
			else
				prio_r = PRIO_BITS'($urandom);
			send_op(kind_r, id_r, TYPE_BITS'($urandom), prio_r);
		end
		quiet = 1'b0;
		req_ch.valid <= 1'b0;

		@(posedge clk);
		wait (pending == 0);
		repeat (100) @(posedge clk);

		$display("sent %0d inserts and %0d removes, %0d results checked",
			n_insert, n_remove, checked);
		$display("queue peaked at %0d of %0d entries, one long result stall and one drain pause",
			peak_fill, CAPACITY);
		if (fail_count == 0 && pending == 0) begin
			$display("** stable_priority_queue: PASSED **");
		end else begin
			$display("** stable_priority_queue: FAILED **");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_ram.sv
hw/rtl/spq_ctrl.sv
hw/rtl/stable_priority_queue.sv
sim/spq_checker.sv
sim/tb_top.sv
